// ===== rtl/xcfr_pkg.sv =====
// package for the xor checked frame receiver
// holds store sizing, marker bytes and the structs passed between modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package xcfr_pkg;

  // frame store sizing
  localparam int unsigned STORE_DEPTH = 128;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned LEN_W       = $clog2(STORE_DEPTH + 1);

  typedef logic [7:0]       byte_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam idx_t  IDX_LAST  = idx_t'(STORE_DEPTH - 1);
  localparam len_t  LEN_DEPTH = len_t'(STORE_DEPTH);
  localparam len_t  LEN_MIN   = len_t'(3);
  localparam len_t  LEN_TAIL  = len_t'(2);
  localparam idx_t  IDX_CMD   = idx_t'(1);
  localparam idx_t  IDX_LEN   = idx_t'(2);

  // marker bytes
  localparam byte_t HDR_FIRST  = 8'hCA;
  localparam byte_t HDR_SECOND = 8'hAC;
  localparam byte_t END_MARK   = 8'hCC;

  // store read port driven by the walk
  typedef struct packed {
    logic en;
    idx_t addr;
  } rd_req_t;

  // walk start request
  typedef struct packed {
    logic valid;
    idx_t last_idx;
  } walk_req_t;

  // walk completion status
  typedef struct packed {
    logic valid;
    logic pass;
  } walk_done_t;

endpackage

`default_nettype wire

// ===== rtl/xcfr_store.sv =====
// frame byte store: one write port, one read port with registered data
// depends on xcfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module xcfr_store (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire xcfr_pkg::idx_t   wr_addr_i,
  input  wire xcfr_pkg::byte_t  wr_data_i,
  input  wire xcfr_pkg::rd_req_t rd_i,
  output xcfr_pkg::byte_t       rd_data_o
);

  xcfr_pkg::byte_t mem_q [xcfr_pkg::STORE_DEPTH];
  xcfr_pkg::byte_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/xcfr_xor_walk.sv =====
// xor checksum walk: reads stored bytes 0 .. last one per cycle through the
// store read port, folds them in a shared xor accumulator, compares at the end
// depends on xcfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module xcfr_xor_walk (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire xcfr_pkg::walk_req_t  req_i,
  input  wire xcfr_pkg::byte_t      rd_data_i,
  output xcfr_pkg::rd_req_t         rd_o,
  output xcfr_pkg::walk_done_t      done_o
);

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_READ = 3'b010,
    W_LAST = 3'b100
  } walk_state_e;

  walk_state_e     state_q, state_d;
  xcfr_pkg::idx_t  addr_q, addr_d;
  xcfr_pkg::idx_t  last_q, last_d;
  xcfr_pkg::idx_t  didx_q, didx_d;
  xcfr_pkg::byte_t acc_q, acc_d;
  logic            dv_q, dv_d;

  // read address sequencer
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    last_d    = last_q;
    didx_d    = didx_q;
    dv_d      = 1'b0;
    rd_o.en   = 1'b0;
    rd_o.addr = addr_q;
    unique case (state_q)
      W_IDLE: begin
        if (req_i.valid) begin
          addr_d  = '0;
          last_d  = req_i.last_idx;
          state_d = W_READ;
        end
      end
      W_READ: begin
        rd_o.en = 1'b1;
        dv_d    = 1'b1;
        didx_d  = addr_q;
        if (addr_q == last_q) begin
          state_d = W_LAST;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      W_LAST: begin
        state_d = W_IDLE;
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  // shared xor accumulate and final compare
  always_comb begin
    acc_d         = acc_q;
    done_o.valid  = 1'b0;
    done_o.pass   = 1'b0;
    if (dv_q) begin
      if (didx_q == last_q) begin
        done_o.valid = 1'b1;
        done_o.pass  = (acc_q == rd_data_i);
      end else if (didx_q == '0) begin
        acc_d = rd_data_i;
      end else begin
        acc_d = acc_q ^ rd_data_i;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dv_q    <= dv_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    last_q <= last_d;
    didx_q <= didx_d;
    acc_q  <= acc_d;
  end

  // completion only when the last byte is back from the store
  a_done_in_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o.valid |-> (state_q == W_LAST))
    else $error("walk done outside last state");

  a_last_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_LAST) |-> (dv_q && didx_q == last_q))
    else $error("last state without final byte");

  a_addr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_READ) |-> (addr_q <= last_q))
    else $error("walk address past final index");

endmodule

`default_nettype wire

// ===== rtl/xor_checked_frame_receiver.sv =====
// top level of the xor checked frame receiver: byte parsing, write index,
// output register; uses xcfr_store and xcfr_xor_walk, depends on xcfr_pkg
//
//   channel  dir  beat contents
//   s_axis   in   tdata[7:0] rx_byte
//   m_axis   out  tdata[7:0] command, tuser[0] frame_good, tuser[1] check_failed
//
// a byte that does not close a frame has its result in the output register in the
// cycle after the accept, and a next byte can follow at once if that beat is taken
// a closing byte starts the checksum walk over the store, limited by its single
// read port: s_axis_tready_o stays low while the walk runs, result valid after that
// reset clears the write index, header flag and handshake state; the store
// keeps whatever it held
// a stalled output holds its beat and blocks new input until that beat is
// taken; a new byte can be taken in the cycle the waiting beat leaves
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_receiver (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] command
  output logic [1:0]      m_axis_tuser_o    // [0] frame_good, [1] check_failed
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } rx_state_e;

  rx_state_e             state_q, state_d;
  xcfr_pkg::idx_t        wr_idx_q, wr_idx_d;
  logic                  first_q, first_d;
  xcfr_pkg::byte_t       byte1_q, byte2_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_good_q, out_good_d;
  logic                  out_fail_q, out_fail_d;
  xcfr_pkg::byte_t       out_cmd_q, out_cmd_d;

  xcfr_pkg::byte_t       rx_byte;
  logic                  accept;
  logic                  is_ca, is_ac, is_cc, hdr_restart, close;
  xcfr_pkg::len_t        len;
  xcfr_pkg::idx_t        next_idx;
  xcfr_pkg::byte_t       byte2_now;
  xcfr_pkg::walk_req_t   walk_req;
  xcfr_pkg::walk_done_t  walk_done;
  xcfr_pkg::rd_req_t     rd_req;
  xcfr_pkg::byte_t       rd_data;

  assign rx_byte         = s_axis_tdata_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // byte classification and close check
  always_comb begin
    is_ca       = (rx_byte == xcfr_pkg::HDR_FIRST);
    is_ac       = (rx_byte == xcfr_pkg::HDR_SECOND);
    is_cc       = (rx_byte == xcfr_pkg::END_MARK);
    hdr_restart = is_ac && first_q;
    len         = xcfr_pkg::len_t'(wr_idx_q) + 1'b1;
    next_idx    = (len >= xcfr_pkg::LEN_DEPTH) ? xcfr_pkg::IDX_LAST
                                               : xcfr_pkg::idx_t'(len);
    byte2_now   = (wr_idx_q == xcfr_pkg::IDX_LEN) ? rx_byte : byte2_q;
    close       = !is_ca && !is_ac && is_cc && (len >= xcfr_pkg::LEN_MIN)
                  && (xcfr_pkg::byte_t'(len) == byte2_now);
  end

  // walk start: compare target is stored byte length-2
  always_comb begin
    walk_req.valid    = accept && close;
    walk_req.last_idx = xcfr_pkg::idx_t'(len - xcfr_pkg::LEN_TAIL);
  end

  // sequencer, index and output register next state
  always_comb begin
    state_d     = state_q;
    wr_idx_d    = wr_idx_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    out_good_d  = out_good_q;
    out_fail_d  = out_fail_q;
    out_cmd_d   = out_cmd_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          first_d  = is_ca || hdr_restart;
          wr_idx_d = hdr_restart ? '0 : next_idx;
          if (close) begin
            state_d = S_WALK;
          end else begin
            out_valid_d = 1'b1;
            out_good_d  = 1'b0;
            out_fail_d  = 1'b0;
            out_cmd_d   = '0;
          end
        end
      end
      S_WALK: begin
        if (walk_done.valid) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_good_d  = walk_done.pass;
          out_fail_d  = !walk_done.pass;
          out_cmd_d   = walk_done.pass ? byte1_q : '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_idx_q    <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and shadow copies of stored bytes 1 and 2
  always_ff @(posedge clk_i) begin
    out_good_q <= out_good_d;
    out_fail_q <= out_fail_d;
    out_cmd_q  <= out_cmd_d;
    if (accept && !hdr_restart && wr_idx_q == xcfr_pkg::IDX_CMD) begin
      byte1_q <= rx_byte;
    end
    if (accept && !hdr_restart && wr_idx_q == xcfr_pkg::IDX_LEN) begin
      byte2_q <= rx_byte;
    end
  end

  xcfr_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && !hdr_restart),
    .wr_addr_i (wr_idx_q),
    .wr_data_i (rx_byte),
    .rd_i      (rd_req),
    .rd_data_o (rd_data)
  );

  xcfr_xor_walk u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (walk_req),
    .rd_data_i (rd_data),
    .rd_o      (rd_req),
    .done_o    (walk_done)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_cmd_q;
  assign m_axis_tuser_o  = {out_fail_q, out_good_q};

  // output slot stays empty while a walk runs
  a_no_out_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> !out_valid_q)
    else $error("result pending during checksum walk");

  // walk completes only while the sequencer waits for it
  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done.valid |-> (state_q == S_WALK))
    else $error("walk done while idle");

  // a closed frame is either good or failed, command only when good
  a_result_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!(out_good_q && out_fail_q) && (out_good_q || out_cmd_q == '0)))
    else $error("inconsistent result flags");

endmodule

`default_nettype wire

// ===== verif/xor_checked_frame_receiver_tb.sv =====
// self-checking testbench for xor_checked_frame_receiver: drives header-led
// frames and noise through s_axis, predicts every m_axis beat and compares
// depends on xcfr_pkg and the rtl top level only
`timescale 1ns / 1ps

module xor_checked_frame_receiver_tb;

  // one expected m_axis beat
  typedef struct packed {
    logic            good;
    logic            failed;
    xcfr_pkg::byte_t cmd;
  } verdict_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid   = 1'b0;
  logic [7:0] s_axis_tdata    = 8'h00;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic       m_axis_tready   = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  xcfr_pkg::byte_t rx_bytes_q [$];   // bytes waiting to be offered
  verdict_t        verdict_q [$];    // predicted beats not yet seen
  int unsigned     n_queued   = 0;
  int unsigned     n_errors   = 0;
  int unsigned     burst_left = 0;
  int unsigned     gap_left   = 0;
  logic [9:0]      stall_phase = '0;

  // shadow copy of the deframer state
  xcfr_pkg::byte_t shadow_store [xcfr_pkg::STORE_DEPTH];
  int unsigned     shadow_wr_idx   = 0;
  bit              shadow_hdr_seen = 1'b0;

  xor_checked_frame_receiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // write into the shadow store, clamping at the last entry
  function automatic void shadow_put(xcfr_pkg::byte_t b);
    int unsigned idx;
    idx = (shadow_wr_idx >= xcfr_pkg::STORE_DEPTH) ? xcfr_pkg::STORE_DEPTH - 1
                                                   : shadow_wr_idx;
    shadow_store[idx] = b;
    shadow_wr_idx = idx + 1;
  endfunction

  // advance the shadow deframer by one byte and return the beat it yields
  function automatic verdict_t deframe_byte(xcfr_pkg::byte_t b);
    verdict_t        v;
    int unsigned     span;
    xcfr_pkg::byte_t acc;
    v = '0;
    if (b == xcfr_pkg::HDR_FIRST) begin
      shadow_put(b);
      shadow_hdr_seen = 1'b1;
    end else if (b == xcfr_pkg::HDR_SECOND && shadow_hdr_seen) begin
      shadow_wr_idx = 0;
    end else begin
      shadow_put(b);
      shadow_hdr_seen = 1'b0;
      span = shadow_wr_idx;
      // close check: length matched and end marker just stored
      if (b == xcfr_pkg::END_MARK && span >= 3 && span == shadow_store[2]) begin
        acc = shadow_store[0];
        for (int unsigned i = 1; i + 2 < span; i++) acc ^= shadow_store[i];
        if (acc == shadow_store[span-2]) begin
          v.good = 1'b1;
          v.cmd  = shadow_store[1];
        end else begin
          v.failed = 1'b1;
        end
      end
    end
    if (shadow_wr_idx >= xcfr_pkg::STORE_DEPTH) shadow_wr_idx = xcfr_pkg::STORE_DEPTH - 1;
    return v;
  endfunction

  task automatic queue_byte(xcfr_pkg::byte_t b);
    rx_bytes_q.push_back(b);
    n_queued++;
  endtask

  // random payload byte that never restarts the frame after a first header
  function automatic xcfr_pkg::byte_t fill_byte();
    xcfr_pkg::byte_t v;
    v = xcfr_pkg::byte_t'($urandom);
    if (v == xcfr_pkg::HDR_SECOND) v = ~v;
    return v;
  endfunction

  // header variants: plain, repeated first byte, repeated second byte
  task automatic queue_header();
    int unsigned pick;
    pick = $urandom_range(9);
    queue_byte(xcfr_pkg::HDR_FIRST);
    if (pick == 0) queue_byte(xcfr_pkg::HDR_FIRST);
    queue_byte(xcfr_pkg::HDR_SECOND);
    if (pick == 1) queue_byte(xcfr_pkg::HDR_SECOND);
  endtask

  // frame body of len bytes: fill, command, length, ..., checksum, end marker
  task automatic queue_frame(int unsigned len, xcfr_pkg::byte_t cmd, bit bad_sum,
                             bit bad_end);
    xcfr_pkg::byte_t body [256];
    xcfr_pkg::byte_t sum;
    for (int unsigned i = 0; i < len; i++) body[i] = fill_byte();
    body[1] = cmd;
    body[2] = xcfr_pkg::byte_t'(len);
    // a four-byte frame carries its checksum in the length slot
    if (len == 4) begin
      body[0] = cmd ^ 8'd4;
    end else begin
      sum = body[0];
      for (int unsigned i = 1; i + 2 < len; i++) sum ^= body[i];
      body[len-2] = sum;
    end
    if (bad_sum) body[0] ^= xcfr_pkg::byte_t'(1 << $urandom_range(7));
    body[len-1] = bad_end ? xcfr_pkg::byte_t'($urandom_range(8'hCD, 8'hFF))
                          : xcfr_pkg::END_MARK;
    for (int unsigned i = 0; i < len; i++) queue_byte(body[i]);
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(4, 16);
    if (r < 97) return $urandom_range(17, 48);
    if (r < 99) return $urandom_range(100, xcfr_pkg::STORE_DEPTH - 1);
    return xcfr_pkg::STORE_DEPTH;
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0 || rx_bytes_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_bytes_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern rotating through four modes
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(1) == 1);
      2'd2:    m_axis_tready <= ($urandom_range(3) == 0);
      default: m_axis_tready <= (stall_phase[2:0] != 3'd0);
    endcase
  end

  // monitor: check result beats, predict on accepted input beats
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %0h tuser %0b",
                 m_axis_tdata, m_axis_tuser);
          n_errors++;
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tuser[0] !== want.good) begin
            $error("frame_good: expected %0d, got %0d", want.good, m_axis_tuser[0]);
            n_errors++;
          end
          if (m_axis_tuser[1] !== want.failed) begin
            $error("check_failed: expected %0d, got %0d", want.failed, m_axis_tuser[1]);
            n_errors++;
          end
          if (m_axis_tdata !== want.cmd) begin
            $error("command: expected %0h, got %0h", want.cmd, m_axis_tdata);
            n_errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) verdict_q.push_back(deframe_byte(s_axis_tdata));
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned kind;
    int unsigned len;

    // directed: stray second header byte and data extremes
    queue_byte(xcfr_pkg::HDR_SECOND);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    // double second header byte, then shortest closable frame, command zero
    queue_byte(xcfr_pkg::HDR_FIRST);
    queue_byte(xcfr_pkg::HDR_SECOND);
    queue_byte(xcfr_pkg::HDR_SECOND);
    queue_frame(4, 8'h00, 1'b0, 1'b0);
    // double first header byte, then a frame with a broken checksum
    queue_byte(xcfr_pkg::HDR_FIRST);
    queue_byte(xcfr_pkg::HDR_FIRST);
    queue_byte(xcfr_pkg::HDR_SECOND);
    queue_frame(5, 8'hFF, 1'b1, 1'b0);
    // length matched but last byte is not the end marker
    queue_byte(xcfr_pkg::HDR_FIRST);
    queue_byte(xcfr_pkg::HDR_SECOND);
    queue_frame(5, 8'h5A, 1'b0, 1'b1);
    // good five-byte frame
    queue_byte(xcfr_pkg::HDR_FIRST);
    queue_byte(xcfr_pkg::HDR_SECOND);
    queue_frame(5, 8'hA5, 1'b0, 1'b0);

    // random: mostly well-formed frames, the rest broken frames and noise
    while (n_queued < 1850) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        len = pick_len();
        queue_header();
        queue_frame(len, xcfr_pkg::byte_t'($urandom), 1'b0, 1'b0);
        // overrun of a full store: last entry rewritten, then closed again
        if (len == xcfr_pkg::STORE_DEPTH && $urandom_range(1) == 1) begin
          queue_byte(fill_byte());
          queue_byte(xcfr_pkg::END_MARK);
        end
      end else if (kind < 78) begin
        queue_header();
        queue_frame(pick_len(), xcfr_pkg::byte_t'($urandom), 1'b1, 1'b0);
      end else if (kind < 84) begin
        queue_header();
        queue_frame(pick_len(), xcfr_pkg::byte_t'($urandom), 1'b0, 1'b1);
      end else if (kind < 89) begin
        // truncated frame, cut off by whatever follows
        queue_header();
        repeat ($urandom_range(1, 6)) queue_byte(fill_byte());
      end else if (kind < 90) begin
        // length beyond the store: never closes, index pinned at the end
        queue_header();
        queue_frame($urandom_range(xcfr_pkg::STORE_DEPTH + 1, xcfr_pkg::STORE_DEPTH + 10),
                    xcfr_pkg::byte_t'($urandom), 1'b0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(4))
            0:       queue_byte(xcfr_pkg::HDR_FIRST);
            1:       queue_byte(xcfr_pkg::HDR_SECOND);
            2:       queue_byte(xcfr_pkg::END_MARK);
            default: queue_byte(xcfr_pkg::byte_t'($urandom));
          endcase
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all bytes accepted, all results seen, then a quiet tail
    while (rx_bytes_q.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (xcfr_pkg::STORE_DEPTH + 40) @(negedge clk_i);

    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
